// ===== hdl/kcs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcs_pkg: shared types and constants of the half-period regenerator
// Register indexes and reset values, symbol and level codes, and the
// command/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package kcs_pkg;

   // Default width of a duration field
   localparam int DURATION_BITS_DEF = 24;

   // Fixed register widths
   localparam int NOMINAL_W = 16;
   localparam int GAP_W     = 24;
   localparam int QERR_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // Lookahead window
   localparam int WIN_DEPTH = 4;
   localparam int FILL_W    = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_HALF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_HALF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ERROR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_HIGH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_LEVEL = 3'd5;

   // Register reset values
   localparam logic [NOMINAL_W-1:0] SHORT_HALF_RST  = 16'd52;
   localparam logic [NOMINAL_W-1:0] LONG_HALF_RST   = 16'd104;
   localparam logic [GAP_W-1:0]     GAP_LIMIT_RST   = 24'd5000;
   localparam logic [QERR_W-1:0]    MAX_ERROR_RST   = 16'd22938;
   localparam logic                 FORCE_HIGH_RST  = 1'b1;
   localparam logic                 START_LEVEL_RST = 1'b1;

   // Output level codes
   localparam logic [1:0] LEVEL_LOW  = 2'd0;
   localparam logic [1:0] LEVEL_HIGH = 2'd1;
   localparam logic [1:0] LEVEL_GAP  = 2'd2;

   // Symbol kind codes
   localparam logic [1:0] KIND_ZERO     = 2'd0;
   localparam logic [1:0] KIND_ONE      = 2'd1;
   localparam logic [1:0] KIND_FALLBACK = 2'd2;
   localparam logic [1:0] KIND_GAP      = 2'd3;

   // Live configuration (start level only loads the phase, so it is not held)
   typedef struct packed {
      logic [NOMINAL_W-1:0] short_half_ticks;
      logic [NOMINAL_W-1:0] long_half_ticks;
      logic [GAP_W-1:0]     gap_limit_ticks;
      logic [QERR_W-1:0]    max_error_q16;
      logic                 force_high_start;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // take the input item into the window
      logic sum;         // register error sums
      logic mul;         // register cross products
      logic decide;      // register the decision
      logic emit;        // load one half-period into the output register
      logic first_half;  // first half of the current decision
      logic last_half;   // final half of the current decision; window shifts
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       need_decision;
      logic       out_free;
      logic [1:0] count_m1;   // halves of the decision minus one
   } status_type;

endpackage

// ===== hdl/kcs_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcs_req_if: input channel of measured durations
// Valid/ready handshake carrying one duration and the end-of-stream mark.
// ---------------------------------------------------------------------------
interface kcs_req_if #(
   parameter int DURATION_BITS = kcs_pkg::DURATION_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   logic [DURATION_BITS-1:0] duration_ticks;
   logic                     end_of_stream;

   modport source (output valid, output duration_ticks, output end_of_stream,
                   input ready);
   modport sink   (input valid, input duration_ticks, input end_of_stream,
                   output ready);
endinterface

// ===== hdl/kcs_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcs_rsp_if: result channel of regenerated half-periods
// Valid/ready handshake carrying level, duration, symbol kind and flags.
// ---------------------------------------------------------------------------
interface kcs_rsp_if #(
   parameter int DURATION_BITS = kcs_pkg::DURATION_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   logic [1:0]               out_level;
   logic [DURATION_BITS-1:0] out_ticks;
   logic [1:0]               symbol_kind;
   logic                     forced_start;
   logic                     last_of_run;

   modport source (output valid, output out_level, output out_ticks,
                   output symbol_kind, output forced_start, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_level, input out_ticks,
                   input symbol_kind, input forced_start, input last_of_run,
                   output ready);
endinterface

// ===== hdl/kcs_half_period_regenerator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcs_half_period_regenerator_core: KCS half-period regenerator
// Classifies a four-entry lookahead window of measured half-periods as
// bit zero, bit one, single fallback or silence gap, and emits regenerated
// half-periods with alternating level.
//
//   Channel  | Direction | Handshake     | Payload
//   ---------+-----------+---------------+--------------------------------------
//   req_if   | in        | valid/ready   | duration_ticks, end_of_stream
//   rsp_if   | out       | valid/ready   | out_level, out_ticks, symbol_kind,
//            |           |               | forced_start, last_of_run
//   csr_*    | in        | write enable  | csr_index, csr_wr_data
//
// An item that completes no decision holds the input through the take and
// window check steps. Each decision adds error sums, cross products and the
// decision, plus one emit step per regenerated half-period (1, 2 or 4).
// An end-of-stream flush repeats the decision loop until the window is
// empty. The result register stalls only the emit step; a new item is
// taken once all results of the previous one are in the output register.
// Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module kcs_half_period_regenerator_core #(
   parameter int DURATION_BITS = kcs_pkg::DURATION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   kcs_req_if.sink                           req_if,
   kcs_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [kcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kcs_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   kcs_pkg::cfg_type    cfg_ff, cfg_in;
   kcs_pkg::cmd_type    cmd;
   kcs_pkg::status_type status;
   logic                phase_load;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            kcs_pkg::REG_SHORT_HALF:
               cfg_in.short_half_ticks = csr_wr_data[kcs_pkg::NOMINAL_W-1:0];
            kcs_pkg::REG_LONG_HALF:
               cfg_in.long_half_ticks = csr_wr_data[kcs_pkg::NOMINAL_W-1:0];
            kcs_pkg::REG_GAP_LIMIT:
               cfg_in.gap_limit_ticks = csr_wr_data[kcs_pkg::GAP_W-1:0];
            kcs_pkg::REG_MAX_ERROR:
               cfg_in.max_error_q16 = csr_wr_data[kcs_pkg::QERR_W-1:0];
            kcs_pkg::REG_FORCE_HIGH:
               cfg_in.force_high_start = csr_wr_data[0];
            default: begin
               // start level loads the phase directly; others ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_half_ticks <= kcs_pkg::SHORT_HALF_RST;
         cfg_ff.long_half_ticks  <= kcs_pkg::LONG_HALF_RST;
         cfg_ff.gap_limit_ticks  <= kcs_pkg::GAP_LIMIT_RST;
         cfg_ff.max_error_q16    <= kcs_pkg::MAX_ERROR_RST;
         cfg_ff.force_high_start <= kcs_pkg::FORCE_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign phase_load = csr_wr_en && (csr_index == kcs_pkg::REG_START_LEVEL);

   kcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kcs_dp #(
      .DURATION_BITS (DURATION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg_ff),
      .phase_load   (phase_load),
      .phase_value  (csr_wr_data[0]),
      .req_duration (req_if.duration_ticks),
      .req_eos      (req_if.end_of_stream),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_level    (rsp_if.out_level),
      .rsp_ticks    (rsp_if.out_ticks),
      .rsp_kind     (rsp_if.symbol_kind),
      .rsp_forced   (rsp_if.forced_start),
      .rsp_last     (rsp_if.last_of_run)
   );

   // Emit only into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit into occupied output register");

   // One item at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("input taken again before item finished");

   // Run end agrees with the window having nothing left to decide
   a_last_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last_half) |=>
         (rsp_if.valid && (rsp_if.last_of_run == !status.need_decision)))
      else $error("last_of_run disagrees with pending window");

   // A forced start always shows a high level
   a_forced_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.forced_start) |->
         (rsp_if.out_level == kcs_pkg::LEVEL_HIGH))
      else $error("forced start not at high level");

endmodule

// ===== hdl/kcs_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcs_ctrl: sequencing controller
// Steps each item through window load and, when a decision is due, error
// sums, cross products, decision and one emit per regenerated half-period.
// ---------------------------------------------------------------------------
module kcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kcs_pkg::status_type status,
   output kcs_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DEC  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] half_ff, half_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      half_in   = half_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (status.need_decision) begin
               cmd.sum  = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            cmd.decide = 1'b1;
            half_in    = 2'd0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.first_half = (half_ff == 2'd0);
               cmd.last_half  = (half_ff == status.count_m1);
               if (half_ff == status.count_m1) begin
                  state_in = ST_SUM;   // flush may hold further decisions
               end else begin
                  half_in = half_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         half_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         half_ff  <= half_in;
      end
   end

endmodule

// ===== hdl/kcs_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcs_dp: regenerator datapath
// Lookahead window, error sums, cross-multiplied error tests, decision
// registers, level phase and the result output register.
// ---------------------------------------------------------------------------
module kcs_dp #(
   parameter int DURATION_BITS = kcs_pkg::DURATION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kcs_pkg::cmd_type         cmd,
   output kcs_pkg::status_type      status,
   input  kcs_pkg::cfg_type         cfg,
   input  logic                     phase_load,
   input  logic                     phase_value,
   input  logic [DURATION_BITS-1:0] req_duration,
   input  logic                     req_eos,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_level,
   output logic [DURATION_BITS-1:0] rsp_ticks,
   output logic [1:0]               rsp_kind,
   output logic                     rsp_forced,
   output logic                     rsp_last
);

   localparam int DB    = DURATION_BITS;
   localparam int E0_W  = DB + 1;          // two errors
   localparam int E1_W  = DB + 2;          // four errors
   localparam int P0_W  = E0_W + kcs_pkg::NOMINAL_W;
   localparam int P1_W  = E1_W + kcs_pkg::NOMINAL_W;
   localparam int QP_W  = kcs_pkg::QERR_W + kcs_pkg::NOMINAL_W;
   localparam int ACC_W = P1_W;            // covers every compare operand
   localparam int CMP_W = (DB > kcs_pkg::GAP_W) ? DB : kcs_pkg::GAP_W;
   localparam int WIN_W = kcs_pkg::FILL_W;

   function automatic logic [DB-1:0] abs_diff(input logic [DB-1:0] a,
                                              input logic [DB-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [DB-1:0]    win_ff [kcs_pkg::WIN_DEPTH];
   logic [DB-1:0]    win_in [kcs_pkg::WIN_DEPTH];
   logic [WIN_W-1:0] fill_ff, fill_in;
   logic             eos_ff;
   logic [E0_W-1:0]  e0_ff, e0_in;
   logic [E1_W-1:0]  e1_ff, e1_in;
   logic [P0_W-1:0]  p0_ff, p0_in;
   logic [P1_W-1:0]  p1_ff, p1_in;
   logic [QP_W-1:0]  ql_ff, ql_in, qs_ff, qs_in;
   logic [1:0]       kind_ff, kind_in;
   logic [DB-1:0]    ticks_ff, ticks_in;
   logic [1:0]       cnt_m1_ff, cnt_m1_in;
   logic             forced_ff, forced_in;
   logic             phase_ff, phase_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_level_ff, out_level_in;
   logic [DB-1:0]    out_ticks_ff, out_ticks_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic             out_forced_ff, out_forced_in;
   logic             out_last_ff, out_last_in;

   logic [DB-1:0]    s_ext, l_ext;
   logic             have2, have4, zero_le_one, zero_ok, one_ok, gap_hit;
   logic             sym_force;
   logic [DB-1:0]    snap_ticks;
   logic [WIN_W-1:0] fill_after;

   assign s_ext = DB'(cfg.short_half_ticks);
   assign l_ext = DB'(cfg.long_half_ticks);

   // Error sums against the nominals
   always_comb begin
      e0_in = E0_W'(abs_diff(win_ff[0], l_ext)) + E0_W'(abs_diff(win_ff[1], l_ext));
      e1_in = '0;
      for (int i = 0; i < kcs_pkg::WIN_DEPTH; i++) begin
         e1_in = e1_in + E1_W'(abs_diff(win_ff[i], s_ext));
      end
   end

   // Cross products and error limits, one multiplier each
   assign p0_in = P0_W'(e0_ff) * P0_W'(cfg.short_half_ticks);
   assign p1_in = P1_W'(e1_ff) * P1_W'(cfg.long_half_ticks);
   assign ql_in = QP_W'(cfg.max_error_q16) * QP_W'(cfg.long_half_ticks);
   assign qs_in = QP_W'(cfg.max_error_q16) * QP_W'(cfg.short_half_ticks);

   // Decision from registered products
   always_comb begin
      have2       = (fill_ff >= WIN_W'(2));
      have4       = (fill_ff == WIN_W'(kcs_pkg::WIN_DEPTH));
      zero_le_one = (have2 && have4) ? ({p0_ff, 1'b0} <= p1_ff) : 1'b1;
      zero_ok     = have2 && zero_le_one &&
                    (ACC_W'({e0_ff, 16'b0}) <= ACC_W'({ql_ff, 1'b0}));
      one_ok      = have4 && !zero_le_one &&
                    (ACC_W'({e1_ff, 16'b0}) <= ACC_W'({qs_ff, 2'b0}));
      gap_hit     = (cfg.gap_limit_ticks != '0) &&
                    (CMP_W'(win_ff[0]) >= CMP_W'(cfg.gap_limit_ticks));
      snap_ticks  = (abs_diff(win_ff[0], s_ext) <= abs_diff(win_ff[0], l_ext)) ?
                    s_ext : l_ext;
      sym_force   = cfg.force_high_start && !phase_ff;

      kind_in   = kind_ff;
      ticks_in  = ticks_ff;
      cnt_m1_in = cnt_m1_ff;
      forced_in = forced_ff;
      if (cmd.decide) begin
         if (gap_hit) begin
            kind_in   = kcs_pkg::KIND_GAP;
            ticks_in  = win_ff[0];
            cnt_m1_in = 2'd0;
            forced_in = 1'b0;
         end else if (zero_ok) begin
            kind_in   = kcs_pkg::KIND_ZERO;
            ticks_in  = l_ext;
            cnt_m1_in = 2'd1;
            forced_in = sym_force;
         end else if (one_ok) begin
            kind_in   = kcs_pkg::KIND_ONE;
            ticks_in  = s_ext;
            cnt_m1_in = 2'd3;
            forced_in = sym_force;
         end else begin
            kind_in   = kcs_pkg::KIND_FALLBACK;
            ticks_in  = snap_ticks;
            cnt_m1_in = 2'd0;
            forced_in = sym_force;
         end
      end
   end

   // Level phase
   always_comb begin
      phase_in = phase_ff;
      if (phase_load) begin
         phase_in = phase_value;
      end else if (cmd.decide && !gap_hit && sym_force) begin
         phase_in = 1'b1;
      end else if (cmd.emit) begin
         if (kind_ff == kcs_pkg::KIND_GAP) begin
            phase_in = cfg.force_high_start ? 1'b1 : phase_ff;
         end else begin
            phase_in = !phase_ff;
         end
      end
   end

   // Window fill and shift
   assign fill_after = fill_ff - (WIN_W'(cnt_m1_ff) + WIN_W'(1));

   always_comb begin
      logic [WIN_W-1:0] src;
      src     = '0;
      fill_in = fill_ff;
      for (int i = 0; i < kcs_pkg::WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.load) begin
         win_in[fill_ff[1:0]] = req_duration;
         fill_in              = fill_ff + WIN_W'(1);
      end else if (cmd.emit && cmd.last_half) begin
         for (int i = 0; i < kcs_pkg::WIN_DEPTH; i++) begin
            src = WIN_W'(i) + WIN_W'(cnt_m1_ff) + WIN_W'(1);
            if (src < WIN_W'(kcs_pkg::WIN_DEPTH)) begin
               win_in[i] = win_ff[src[1:0]];
            end
         end
         fill_in = fill_after;
      end
   end

   // Output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_level_in  = out_level_ff;
      out_ticks_in  = out_ticks_ff;
      out_kind_in   = out_kind_ff;
      out_forced_in = out_forced_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_level_in  = (kind_ff == kcs_pkg::KIND_GAP) ? kcs_pkg::LEVEL_GAP :
                         (phase_ff ? kcs_pkg::LEVEL_HIGH : kcs_pkg::LEVEL_LOW);
         out_ticks_in  = ticks_ff;
         out_kind_in   = kind_ff;
         out_forced_in = forced_ff && cmd.first_half;
         out_last_in   = cmd.last_half && !(eos_ff && (fill_after != '0));
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         eos_ff       <= 1'b0;
         phase_ff     <= kcs_pkg::START_LEVEL_RST;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (cmd.load) begin
            eos_ff <= req_eos;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < kcs_pkg::WIN_DEPTH; i++) begin
         win_ff[i] <= win_in[i];
      end
      if (cmd.sum) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
      end
      if (cmd.mul) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         ql_ff <= ql_in;
         qs_ff <= qs_in;
      end
      kind_ff       <= kind_in;
      ticks_ff      <= ticks_in;
      cnt_m1_ff     <= cnt_m1_in;
      forced_ff     <= forced_in;
      out_level_ff  <= out_level_in;
      out_ticks_ff  <= out_ticks_in;
      out_kind_ff   <= out_kind_in;
      out_forced_ff <= out_forced_in;
      out_last_ff   <= out_last_in;
   end

   // Status
   assign status.need_decision = (fill_ff == WIN_W'(kcs_pkg::WIN_DEPTH)) ||
                                 (eos_ff && (fill_ff != '0));
   assign status.out_free      = !out_valid_ff || rsp_ready;
   assign status.count_m1      = cnt_m1_ff;

   assign rsp_valid  = out_valid_ff;
   assign rsp_level  = out_level_ff;
   assign rsp_ticks  = out_ticks_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_forced = out_forced_ff;
   assign rsp_last   = out_last_ff;

endmodule
